// ===== design/gauss_jordan_solver_6x6_top_macros.svh =====
// Assertion macros for the solver.
`ifndef GAUSS_JORDAN_SOLVER_6X6_TOP_MACROS_SVH
`define GAUSS_JORDAN_SOLVER_6X6_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GJS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GJS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GJS_ASSERT(label, clk, rst_n, prop, msg)
`define GJS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== design/gjs_pkg.sv =====
`default_nettype none
package gjs_pkg;
    localparam int N = 6;
    localparam int COLS = N + 1;
    localparam int FRAC = 16;
    localparam int DEPTH = N * COLS;
    localparam int AW = $clog2(DEPTH);

    typedef struct packed {
        logic [2:0]         row_index;
        logic [2:0]         column_index;
        logic signed [31:0] element_value;
        logic               load_done;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         solution_index;
        logic signed [31:0] solution_value;
        logic               is_singular;
        logic               last_result;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== design/gauss_jordan_solver_6x6_top.sv =====
// Load: one cycle per transaction. A solve starts after the transaction with load_done.
// Solve: one shared multiplier and a radix-2 divider under a sequencer: it copies the store
// to the work array, then per pivot searches each candidate row, decides, swaps the rows
// column by column, divides each entry from the pivot column on, and eliminates each other
// row entry by entry (read, multiply, write). Results then leave one per accepted transaction.
// No input is taken meanwhile. Reset clears control state and sets pivot_threshold to 1.
`default_nettype none
`include "gauss_jordan_solver_6x6_top_macros.svh"
module gauss_jordan_solver_6x6_top
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire gjs_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output gjs_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire logic [30:0]       cfg_wdata
);
    import gjs_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_COPY, S_SRCH, S_SWRD, S_SWWR, S_DVRD, S_DIV, S_DVWR,
        S_FRD, S_ERD, S_EMUL, S_EWR, S_NEXTP, S_OUT, S_SCMP, S_DVST, S_SWWB
    } state_t;

    state_t state_reg;
    logic [30:0] thr_reg;
    logic signed [31:0] store [DEPTH];
    logic signed [31:0] work [DEPTH];
    logic [2:0] p_reg, r_reg, c_reg, best_reg;
    logic [AW-1:0] cp_reg;
    logic [32:0] bmag_reg;
    logic signed [31:0] a_reg, b_reg, f_reg, pv_reg;
    logic signed [31:0] sv_reg, cdata_reg;
    logic signed [63:0] prod_reg;
    logic [63:0] rem_reg, quo_reg, den_reg;
    logic [5:0] dcnt_reg;
    logic dneg_reg;
    logic sing_reg;
    out_item_t out_reg;
    logic ovalid_reg;

    function automatic logic [AW-1:0] ix(input logic [2:0] r, input logic [2:0] c);
        return AW'(r * COLS + c);
    endfunction

    assign in_stall = (state_reg != S_LOAD);
    assign out_valid = ovalid_reg;
    assign out_data = out_reg;

    logic [32:0] cur_mag;
    logic signed [31:0] cur_val;
    assign cur_val = sv_reg;
    assign cur_mag = cur_val[31] ? 33'(-34'(cur_val)) : 33'(cur_val);

    logic signed [63:0] fl;
    assign fl = prod_reg >>> FRAC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            thr_reg <= 31'd1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        if (in_data.row_index < 3'(N) && in_data.column_index < 3'(COLS))
                            store[ix(in_data.row_index, in_data.column_index)]
                                <= in_data.element_value;
                        if (in_data.load_done)
                        begin
                            cp_reg <= '0;
                            state_reg <= S_COPY;
                        end
                    end
                end
                S_COPY:
                begin
                    // The store read is registered, so each entry reaches the work copy
                    // in the cycle after it is read.
                    if (cp_reg != AW'(DEPTH))
                        cdata_reg <= store[cp_reg];
                    if (cp_reg != '0)
                        work[AW'(cp_reg - 1'b1)] <= cdata_reg;
                    if (cp_reg == AW'(DEPTH))
                    begin
                        p_reg <= '0;
                        r_reg <= '0;
                        bmag_reg <= '0;
                        best_reg <= '0;
                        state_reg <= S_SRCH;
                    end
                    cp_reg <= cp_reg + 1'b1;
                end
                S_SRCH:
                begin
                    sv_reg <= work[ix(r_reg, p_reg)];
                    state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    // Strictly greater keeps the uppermost row on a tie.
                    if (r_reg == p_reg || cur_mag > bmag_reg)
                    begin
                        bmag_reg <= cur_mag;
                        best_reg <= r_reg;
                    end
                    if (r_reg == 3'(N - 1))
                        state_reg <= S_NEXTP;
                    else
                    begin
                        r_reg <= r_reg + 1'b1;
                        state_reg <= S_SRCH;
                    end
                end
                S_NEXTP:
                begin
                    if (bmag_reg == '0 || bmag_reg < {2'b00, thr_reg})
                    begin
                        sing_reg <= 1'b1;
                        out_reg <= '{3'd0, 32'sd0, 1'b1, 1'b1};
                        ovalid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        c_reg <= '0;
                        state_reg <= (best_reg != p_reg) ? S_SWRD : S_DVRD;
                        if (best_reg == p_reg)
                            c_reg <= p_reg;
                    end
                end
                S_SWRD:
                begin
                    a_reg <= work[ix(p_reg, c_reg)];
                    b_reg <= work[ix(best_reg, c_reg)];
                    state_reg <= S_SWWR;
                end
                S_SWWR:
                begin
                    work[ix(p_reg, c_reg)] <= b_reg;
                    state_reg <= S_SWWB;
                end
                S_SWWB:
                begin
                    work[ix(best_reg, c_reg)] <= a_reg;
                    if (c_reg == 3'(COLS - 1))
                    begin
                        c_reg <= p_reg;
                        state_reg <= S_DVRD;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                        state_reg <= S_SWRD;
                    end
                end
                S_DVRD:
                begin
                    // The pivot entry is divided first; its original value stays in pv_reg.
                    a_reg <= work[ix(p_reg, c_reg)];
                    if (c_reg == p_reg)
                        pv_reg <= work[ix(p_reg, c_reg)];
                    state_reg <= S_DVST;
                end
                S_DVST:
                begin : setup
                    logic [63:0] na, nd;
                    na = a_reg[31] ? 64'(-(65'(a_reg) <<< FRAC))
                                   : 64'(65'(a_reg) <<< FRAC);
                    nd = pv_reg[31] ? 64'(-65'(pv_reg)) : 64'(pv_reg);
                    rem_reg <= '0;
                    quo_reg <= na;
                    den_reg <= nd;
                    dneg_reg <= a_reg[31] ^ pv_reg[31];
                    dcnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    begin : step
                        logic [64:0] tr;
                        tr = {rem_reg, quo_reg[63]};
                        if (tr >= {1'b0, den_reg})
                        begin
                            rem_reg <= 64'(tr - {1'b0, den_reg});
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= tr[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 6'd63)
                        state_reg <= S_DVWR;
                end
                S_DVWR:
                begin
                    work[ix(p_reg, c_reg)] <= sat32(dneg_reg ? -66'(quo_reg) : 66'(quo_reg));
                    if (c_reg == 3'(COLS - 1))
                    begin
                        r_reg <= (p_reg == 3'd0) ? 3'd1 : 3'd0;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                        state_reg <= S_DVRD;
                    end
                end
                S_FRD:
                begin
                    f_reg <= work[ix(r_reg, p_reg)];
                    c_reg <= p_reg;
                    state_reg <= S_ERD;
                end
                S_ERD:
                begin
                    a_reg <= work[ix(r_reg, c_reg)];
                    b_reg <= work[ix(p_reg, c_reg)];
                    state_reg <= S_EMUL;
                end
                S_EMUL:
                begin
                    prod_reg <= f_reg * b_reg;
                    state_reg <= S_EWR;
                end
                S_EWR:
                begin
                    work[ix(r_reg, c_reg)] <= sat32(66'(a_reg) - 66'(fl));
                    if (c_reg != 3'(COLS - 1))
                    begin
                        c_reg <= c_reg + 1'b1;
                        state_reg <= S_ERD;
                    end
                    else
                    begin : nxt
                        logic [2:0] nr;
                        nr = r_reg + 1'b1;
                        if (nr == p_reg)
                            nr = nr + 1'b1;
                        if (nr < 3'(N))
                        begin
                            r_reg <= nr;
                            state_reg <= S_FRD;
                        end
                        else if (p_reg == 3'(N - 1))
                        begin
                            sing_reg <= 1'b0;
                            out_reg <= '{3'd0, work[ix(3'd0, 3'(N))], 1'b0, 1'b0};
                            ovalid_reg <= 1'b1;
                            r_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            p_reg <= p_reg + 1'b1;
                            r_reg <= p_reg + 1'b1;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (sing_reg || r_reg == 3'(N - 1))
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            r_reg <= r_reg + 1'b1;
                            out_reg <= '{3'(r_reg + 1'b1), work[ix(3'(r_reg + 1'b1), 3'(N))],
                                         1'b0, (3'(r_reg + 1'b1) == 3'(N - 1))};
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    `GJS_ASSERT(a_busy_no_out, clk, rst_n, (state_reg != S_OUT) |-> !ovalid_reg, "stray valid")
    `GJS_ASSERT(a_hold, clk, rst_n, (ovalid_reg && out_stall) |=> $stable(out_reg), "not held")
    `GJS_ASSERT(a_sing, clk, rst_n, (ovalid_reg && out_reg.is_singular) |-> out_reg.last_result, "no last")
    `GJS_ASSERT(a_stall, clk, rst_n, ovalid_reg |-> in_stall, "input during output")
endmodule
`default_nettype wire
